### rtl/core/m4v_pkg.sv
package m4v_pkg;

	localparam int DATA_W        = 32;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int PAIR_W        = PROD_W + 1;
	localparam int ACC_W         = PROD_W + 2;
	localparam int DIM           = 4;
	localparam int FRAC_BITS_DEF = 16;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [PAIR_W-1:0] pair_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	localparam data_t DATA_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_XFORM = 1'b1
	} req_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic ld_out;
	} pipe_ctl_t;

endpackage

### rtl/core/m4v_lane.sv
module m4v_lane #(
	parameter int FRAC_BITS = m4v_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  m4v_pkg::pipe_ctl_t  ctl,
	input  m4v_pkg::data_t      row [m4v_pkg::DIM],
	input  m4v_pkg::data_t      vec [m4v_pkg::DIM],
	output m4v_pkg::acc_t       sum_s3
);
	import m4v_pkg::*;

	localparam acc_t ROUND = acc_t'(1) << (FRAC_BITS - 1);

	prod_t prod_s1 [DIM];
	pair_t pair_s2 [DIM/2];

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			for (int c = 0; c < DIM; c++) begin
				prod_s1[c] <= prod_t'(row[c]) * prod_t'(vec[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			for (int p = 0; p < DIM/2; p++) begin
				pair_s2[p] <= pair_t'(prod_s1[2*p]) + pair_t'(prod_s1[2*p+1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			sum_s3 <= acc_t'(pair_s2[0]) + acc_t'(pair_s2[1]) + ROUND;
		end
	end

endmodule

### rtl/core/m4v_merge.sv
module m4v_merge #(
	parameter int FRAC_BITS = m4v_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  m4v_pkg::pipe_ctl_t  ctl,
	input  m4v_pkg::acc_t       sum [m4v_pkg::DIM],
	output m4v_pkg::data_t      res [m4v_pkg::DIM],
	output logic                sat
);
	import m4v_pkg::*;

	acc_t  shifted [DIM];
	data_t clamped [DIM];
	logic  [DIM-1:0] over;

	always_comb begin
		for (int k = 0; k < DIM; k++) begin
			shifted[k] = sum[k] >>> FRAC_BITS;
			over[k] = !((&shifted[k][ACC_W-1:DATA_W-1]) || !(|shifted[k][ACC_W-1:DATA_W-1]));
			if (!over[k]) begin
				clamped[k] = shifted[k][DATA_W-1:0];
			end else if (shifted[k][ACC_W-1]) begin
				clamped[k] = DATA_MIN;
			end else begin
				clamped[k] = DATA_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			for (int k = 0; k < DIM; k++) begin
				res[k] <= clamped[k];
			end
			sat <= |over;
		end
	end

endmodule

### rtl/core/mat4_vec4_transform.sv
// 4x4 matrix times 4-vector transform in signed fixed point.
// The input channel (in_valid/in_ready) carries two kinds of beat. A load beat
// writes entry_value into the matrix entry at entry_index (row-major) and
// produces no result; the new entry is seen by the very next beat. A transform
// beat multiplies the stored matrix by vec_x..vec_w and produces one result
// beat on the output channel (out_valid/out_ready).
// Each of the four row lanes runs four parallel products, sixteen in all, through a
// four-stage pipeline: multiply, pairwise add, final add with rounding, then
// a merge stage that shifts, saturates and collects the saturated flag into
// the output register. One beat is accepted every cycle while the receiver
// keeps taking results.
// When the receiver stalls, the held result stays in the output register
// and the pipeline keeps accepting beats until every stage is full; in_ready
// then drops until out_ready frees a slot.
// Reset empties the pipeline and clears every matrix entry to zero.
module mat4_vec4_transform #(
	parameter int FRAC_BITS = m4v_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            req_type,
	input  logic [3:0]      entry_index,
	input  m4v_pkg::data_t  entry_value,
	input  m4v_pkg::data_t  vec_x,
	input  m4v_pkg::data_t  vec_y,
	input  m4v_pkg::data_t  vec_z,
	input  m4v_pkg::data_t  vec_w,
	output logic            out_valid,
	input  logic            out_ready,
	output m4v_pkg::data_t  res_x,
	output m4v_pkg::data_t  res_y,
	output m4v_pkg::data_t  res_z,
	output m4v_pkg::data_t  res_w,
	output logic            saturated
);
	import m4v_pkg::*;

	data_t     mat_q [DIM*DIM];
	data_t     vec [DIM];
	data_t     rows [DIM][DIM];
	acc_t      sums [DIM];
	data_t     res [DIM];
	pipe_ctl_t ctl;
	logic      v_s1, v_s2, v_s3;
	logic      in_acc, load_acc;

	assign vec[0] = vec_x;
	assign vec[1] = vec_y;
	assign vec[2] = vec_z;
	assign vec[3] = vec_w;

	always_comb begin
		ctl.ld_out = v_s3 && (!out_valid || out_ready);
		ctl.en_s3  = v_s2 && (!v_s3 || ctl.ld_out);
		ctl.en_s2  = v_s1 && (!v_s2 || ctl.en_s3);
		in_ready   = !v_s1 || ctl.en_s2;
		in_acc     = in_valid && in_ready;
		ctl.en_s1  = in_acc && (req_t'(req_type) == REQ_XFORM);
		load_acc   = in_acc && (req_t'(req_type) == REQ_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= ctl.en_s1 || (v_s1 && !ctl.en_s2);
			v_s2      <= ctl.en_s2 || (v_s2 && !ctl.en_s3);
			v_s3      <= ctl.en_s3 || (v_s3 && !ctl.ld_out);
			out_valid <= ctl.ld_out || (out_valid && !out_ready);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM*DIM; i++) begin
				mat_q[i] <= '0;
			end
		end else if (load_acc) begin
			mat_q[entry_index] <= entry_value;
		end
	end

	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			for (int c = 0; c < DIM; c++) begin
				rows[r][c] = mat_q[r*DIM + c];
			end
		end
	end

	for (genvar r = 0; r < DIM; r++) begin : g_lane
		m4v_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk   (clk),
			.ctl   (ctl),
			.row   (rows[r]),
			.vec   (vec),
			.sum_s3(sums[r])
		);
	end

	m4v_merge #(
		.FRAC_BITS(FRAC_BITS)
	) u_merge (
		.clk(clk),
		.ctl(ctl),
		.sum(sums),
		.res(res),
		.sat(saturated)
	);

	assign res_x = res[0];
	assign res_y = res[1];
	assign res_z = res[2];
	assign res_w = res[3];

`ifndef SYNTH
	a_load_written: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> mat_q[$past(entry_index)] == $past(entry_value))
		else $error("matrix entry not updated by load beat");

	a_xform_enters: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.en_s1 |=> v_s1)
		else $error("transform beat did not enter the pipeline");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !ctl.ld_out |=> v_s3)
		else $error("final sum stage dropped a pending result");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(res_x == DATA_MAX || res_x == DATA_MIN || res_y == DATA_MAX ||
			 res_y == DATA_MIN || res_z == DATA_MAX || res_z == DATA_MIN ||
			 res_w == DATA_MAX || res_w == DATA_MIN))
		else $error("saturated flag set without a clamped component");
`endif

endmodule

### tb/xform_checker.sv
`timescale 1ns / 1ps

module xform_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  logic           req_type,
	input  logic [3:0]     entry_index,
	input  m4v_pkg::data_t entry_value,
	input  m4v_pkg::data_t vec_x,
	input  m4v_pkg::data_t vec_y,
	input  m4v_pkg::data_t vec_z,
	input  m4v_pkg::data_t vec_w,
	input  logic           out_valid,
	input  logic           out_ready,
	input  m4v_pkg::data_t res_x,
	input  m4v_pkg::data_t res_y,
	input  m4v_pkg::data_t res_z,
	input  m4v_pkg::data_t res_w,
	input  logic           saturated,
	output int             mismatches,
	output int             awaited
);
	import m4v_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;

	typedef logic signed [71:0] wide_t;

	typedef struct packed {
		data_t x;
		data_t y;
		data_t z;
		data_t w;
		logic  sat;
	} vec_result_t;

	data_t       matrix_copy [16];
	vec_result_t expected_results [$];
	int          fail_total = 0;

	function automatic vec_result_t transform_vector(data_t vx, data_t vy, data_t vz, data_t vw);
		data_t       comp [4];
		data_t       row_out [4];
		vec_result_t r;
		prod_t       p;
		wide_t       sum;
		comp[0] = vx;
		comp[1] = vy;
		comp[2] = vz;
		comp[3] = vw;
		r.sat   = 1'b0;
		for (int row = 0; row < 4; row++) begin
			sum = '0;
			for (int col = 0; col < 4; col++) begin
				p   = prod_t'(matrix_copy[row * 4 + col]) * prod_t'(comp[col]);
				sum = sum + wide_t'(p);
			end
			sum = sum + (wide_t'(1) <<< (FRAC - 1));
			sum = sum >>> FRAC;
			if (sum > wide_t'(DATA_MAX)) begin
				row_out[row] = DATA_MAX;
				r.sat        = 1'b1;
			end else if (sum < wide_t'(DATA_MIN)) begin
				row_out[row] = DATA_MIN;
				r.sat        = 1'b1;
			end else begin
				row_out[row] = data_t'(sum);
			end
		end
		r.x = row_out[0];
		r.y = row_out[1];
		r.z = row_out[2];
		r.w = row_out[3];
		return r;
	endfunction

	task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		vec_result_t want;
		if (!arst_n) begin
			foreach (matrix_copy[i]) matrix_copy[i] = '0;
			expected_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no transform pending: res_x %0d", res_x);
					fail_total++;
				end else begin
					want = expected_results.pop_front();
					check_field("res_x", want.x, res_x);
					check_field("res_y", want.y, res_y);
					check_field("res_z", want.z, res_z);
					check_field("res_w", want.w, res_w);
					check_field("saturated", 32'(want.sat), 32'(saturated));
				end
			end
			if (in_valid && in_ready) begin
				if (req_type == REQ_LOAD) begin
					matrix_copy[entry_index] = entry_value;
				end else begin
					expected_results.push_back(transform_vector(vec_x, vec_y, vec_z, vec_w));
				end
			end
		end
		mismatches <= fail_total;
		awaited    <= expected_results.size();
	end

endmodule

### tb/tb_mat4_vec4_transform.sv
`timescale 1ns / 1ps

module tb_mat4_vec4_transform;
	import m4v_pkg::*;

	localparam int    IDLE_LIMIT   = 2000;
	localparam int    RANDOM_BEATS = 1030;
	localparam data_t ONE          = 32'sh0001_0000;
	localparam data_t HALF         = 32'sh0000_8000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       req_type;
	logic [3:0] entry_index;
	data_t      entry_value;
	data_t      vec_x;
	data_t      vec_y;
	data_t      vec_z;
	data_t      vec_w;
	logic       out_valid;
	logic       out_ready;
	data_t      res_x;
	data_t      res_y;
	data_t      res_z;
	data_t      res_w;
	logic       saturated;
	int         mismatches;
	int         awaited;
	int         idle_cycles = 0;
	bit         calm = 1'b0;

	mat4_vec4_transform DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.vec_x       (vec_x),
		.vec_y       (vec_y),
		.vec_z       (vec_z),
		.vec_w       (vec_w),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res_x       (res_x),
		.res_y       (res_y),
		.res_z       (res_z),
		.res_w       (res_w),
		.saturated   (saturated)
	);

	xform_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.vec_x       (vec_x),
		.vec_y       (vec_y),
		.vec_z       (vec_z),
		.vec_w       (vec_w),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res_x       (res_x),
		.res_y       (res_y),
		.res_z       (res_z),
		.res_w       (res_w),
		.saturated   (saturated),
		.mismatches  (mismatches),
		.awaited     (awaited)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("FAIL mat4_vec4_transform");
		$finish;
	end

	function automatic int pick_gap();
		return calm ? 0 : int'($urandom_range(0, 12));
	endfunction

	function automatic data_t rand_fixed();
		case ($urandom_range(0, 7))
			0, 1: return data_t'($urandom);
			2: case ($urandom_range(0, 5))
				0: return DATA_MAX;
				1: return DATA_MIN;
				2: return '0;
				3: return ONE;
				4: return -ONE;
				default: return data_t'(1);
			endcase
			3, 4: return data_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
			5: return data_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
			6: return {16'($urandom), HALF[15:0]};
			default: return data_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
		endcase
	endfunction

	task automatic send_beat(req_t kind, logic [3:0] idx, data_t val,
			data_t x, data_t y, data_t z, data_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= kind;
		entry_index <= idx;
		entry_value <= val;
		vec_x       <= x;
		vec_y       <= y;
		vec_z       <= z;
		vec_w       <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_entry(logic [3:0] idx, data_t val);
		send_beat(REQ_LOAD, idx, val, rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
	endtask

	task automatic transform(data_t x, data_t y, data_t z, data_t w);
		send_beat(REQ_XFORM, 4'($urandom), rand_fixed(), x, y, z, w);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
	endtask

	initial begin
		int stall;
		out_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		req_type    <= REQ_LOAD;
		entry_index <= '0;
		entry_value <= '0;
		vec_x       <= '0;
		vec_y       <= '0;
		vec_z       <= '0;
		vec_w       <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		transform(DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX);
		for (int i = 0; i < 4; i++) load_entry(4'(i), DATA_MAX);
		for (int i = 4; i < 8; i++) load_entry(4'(i), DATA_MIN);
		for (int i = 8; i < 16; i++) load_entry(4'(i), '0);
		load_entry(4'd10, ONE);
		load_entry(4'd12, data_t'(1));
		transform(DATA_MAX, DATA_MAX, DATA_MAX, DATA_MAX);
		transform(DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN);
		// Row three scales vec_x by one LSB, so half-step inputs land on rounding ties.
		transform(HALF, '0, -HALF, '0);
		transform(-HALF, DATA_MAX, HALF, DATA_MIN);
		transform(3 * HALF, DATA_MIN, DATA_MAX, ONE);
		wait_drain();

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if ($urandom_range(0, 63) == 0) calm = !calm;
			if ($urandom_range(0, 199) == 0) wait_drain();
			if ($urandom_range(0, 9) < 3) begin
				load_entry(4'($urandom), rand_fixed());
			end else begin
				transform(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
			end
		end

		wait_drain();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS mat4_vec4_transform");
		end else begin
			$display("FAIL mat4_vec4_transform");
		end
		$finish;
	end

endmodule
